### rtl/bdlp_pkg.sv
// Shared types and constants for the button debounce / long-press block.
package bdlp_pkg;

  localparam int TIME_W   = 32;
  localparam int CFG_W    = 16;
  localparam int PINS     = 8;
  localparam int BIDX_W   = 3;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 1'd1;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd20;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd1000;

  typedef enum logic [2:0] {
    EV_PRESS        = 3'd0,
    EV_RELEASE      = 3'd1,
    EV_CLICK        = 3'd2,
    EV_LONG_PRESS   = 3'd3,
    EV_LONG_RELEASE = 3'd4
  } ev_code_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_EMIT,
    ST_FLUSH
  } seq_state_t;

  typedef struct packed {
    logic              raw_level;
    logic              stable_level;
    logic              long_reported;
    logic [TIME_W-1:0] change_stamp;
    logic [TIME_W-1:0] press_stamp;
  } key_state_t;

  typedef struct packed {
    logic [1:0] cnt;
    ev_code_t   ev0;
    ev_code_t   ev1;
  } eval_res_t;

endpackage

### rtl/bdlp_state_mem.sv
// Per-button state memory: registered read, valid bits give zero reset.
module bdlp_state_mem import bdlp_pkg::*; #(
  parameter int DEPTH = 8,
  parameter int IDX_W = 3
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output key_state_t       rd_data,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  key_state_t       wr_data
);

  key_state_t mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  key_state_t rd_q_r;
  logic       rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

### rtl/bdlp_eval.sv
// Update of one button's state from its raw level, with the events it raises.
module bdlp_eval import bdlp_pkg::*; (
  input  key_state_t        cur,
  input  logic              raw,
  input  logic [TIME_W-1:0] now_time,
  input  logic [CFG_W-1:0]  debounce_time,
  input  logic [CFG_W-1:0]  long_press_time,
  output key_state_t        upd,
  output eval_res_t         res
);

  logic [TIME_W-1:0] chg_stamp;
  logic [TIME_W-1:0] press_stamp;
  logic              accept;
  logic              stable;
  logic              long_rep;
  logic              long_hit;

  always_comb begin
    chg_stamp = (raw != cur.raw_level) ? now_time : cur.change_stamp;
    accept    = (raw != cur.stable_level) &&
                ((now_time - chg_stamp) >= {{(TIME_W-CFG_W){1'b0}}, debounce_time});
    stable      = accept ? raw : cur.stable_level;
    press_stamp = (accept && raw) ? now_time : cur.press_stamp;
    long_rep    = (accept && raw) ? 1'b0 : cur.long_reported;
    long_hit    = stable && !long_rep &&
                  ((now_time - press_stamp) >= {{(TIME_W-CFG_W){1'b0}}, long_press_time});

    res.cnt = 2'd0;
    res.ev0 = EV_PRESS;
    res.ev1 = EV_LONG_PRESS;
    if (accept && raw) begin
      res.ev0 = EV_PRESS;
      res.ev1 = EV_LONG_PRESS;
      res.cnt = long_hit ? 2'd2 : 2'd1;
    end else if (accept) begin
      res.ev0 = EV_RELEASE;
      res.ev1 = cur.long_reported ? EV_LONG_RELEASE : EV_CLICK;
      res.cnt = 2'd2;
    end else if (long_hit) begin
      res.ev0 = EV_LONG_PRESS;
      res.cnt = 2'd1;
    end

    upd.raw_level     = raw;
    upd.stable_level  = stable;
    upd.long_reported = long_rep | long_hit;
    upd.change_stamp  = chg_stamp;
    upd.press_stamp   = press_stamp;
  end

endmodule

### rtl/button_debounce_long_press.sv
// Debounce and long-press detector for a bank of buttons, one scan per request.
// Each scan walks the live buttons (the first min(NUM_BUTTONS, 8)) in index
// order through a state memory: for each button a memory read, then
// evaluate and write back, then one emit step per event raised, which
// stalls while the output register is full and not taken; a final flush
// step tags the last event. A new scan is taken once the previous one
// has handed its last event to the output register. Each event leaves as
// one output request; tlast marks the final event of the scan, and a scan
// that raises no event produces no output. Buttons beyond the eighth have
// no pin and never report.
module button_debounce_long_press import bdlp_pkg::*; #(
  parameter int NUM_BUTTONS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [39:0]          in_tdata,   // now_time[31:0], pressed_bits[39:32]
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // button_index[2:0], event_code[5:3], zero[7:6]
  output logic                 out_tlast,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int IDX_W  = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int LIVE_N = (NUM_BUTTONS < PINS) ? NUM_BUTTONS : PINS;
  localparam logic [IDX_W-1:0] LAST_BTN = IDX_W'(LIVE_N - 1);

  seq_state_t        state_r, state_nxt;
  logic [IDX_W-1:0]  btn_r, btn_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic [PINS-1:0]   bits_r, bits_nxt;
  ev_code_t          ev0_r, ev0_nxt, ev1_r, ev1_nxt;
  logic [1:0]        ev_cnt_r, ev_cnt_nxt;
  logic              ev_sel_r, ev_sel_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic [BIDX_W-1:0] pend_idx_r, pend_idx_nxt;
  ev_code_t          pend_code_r, pend_code_nxt;
  logic              out_v_r, out_v_nxt;
  logic [BIDX_W-1:0] out_idx_r, out_idx_nxt;
  ev_code_t          out_code_r, out_code_nxt;
  logic              out_last_r, out_last_nxt;
  logic [CFG_W-1:0]  dbt_r, dbt_nxt, lpt_r, lpt_nxt;

  logic              rd_en;
  logic              wr_en;
  key_state_t        rd_data;
  key_state_t        wr_data;
  eval_res_t         res;
  logic              raw;
  logic              out_free;

  bdlp_state_mem #(
    .DEPTH (NUM_BUTTONS),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (btn_r),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (btn_r),
    .wr_data (wr_data)
  );

  assign raw = bits_r[BIDX_W'(btn_r)];

  bdlp_eval u_eval (
    .cur             (rd_data),
    .raw             (raw),
    .now_time        (now_r),
    .debounce_time   (dbt_r),
    .long_press_time (lpt_r),
    .upd             (wr_data),
    .res             (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      dbt_r    <= DEBOUNCE_RST;
      lpt_r    <= LONG_PRESS_RST;
    end else begin
      state_r  <= state_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
      dbt_r    <= dbt_nxt;
      lpt_r    <= lpt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    btn_r       <= btn_nxt;
    now_r       <= now_nxt;
    bits_r      <= bits_nxt;
    ev0_r       <= ev0_nxt;
    ev1_r       <= ev1_nxt;
    ev_cnt_r    <= ev_cnt_nxt;
    ev_sel_r    <= ev_sel_nxt;
    pend_idx_r  <= pend_idx_nxt;
    pend_code_r <= pend_code_nxt;
    out_idx_r   <= out_idx_nxt;
    out_code_r  <= out_code_nxt;
    out_last_r  <= out_last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    btn_nxt       = btn_r;
    now_nxt       = now_r;
    bits_nxt      = bits_r;
    ev0_nxt       = ev0_r;
    ev1_nxt       = ev1_r;
    ev_cnt_nxt    = ev_cnt_r;
    ev_sel_nxt    = ev_sel_r;
    pend_v_nxt    = pend_v_r;
    pend_idx_nxt  = pend_idx_r;
    pend_code_nxt = pend_code_r;
    out_v_nxt     = out_v_r;
    out_idx_nxt   = out_idx_r;
    out_code_nxt  = out_code_r;
    out_last_nxt  = out_last_r;
    dbt_nxt       = dbt_r;
    lpt_nxt       = lpt_r;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    in_tready     = 1'b0;
    out_free      = !out_v_r || out_tready;

    if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE:   dbt_nxt = cfg_wdata;
        REG_LONG_PRESS: lpt_nxt = cfg_wdata;
        default: ;
      endcase
    end

    if (out_v_r && out_tready) begin
      out_v_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          now_nxt   = in_tdata[TIME_W-1:0];
          bits_nxt  = in_tdata[TIME_W +: PINS];
          btn_nxt   = '0;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        rd_en     = 1'b1;
        state_nxt = ST_CALC;
      end
      ST_CALC: begin
        wr_en      = 1'b1;
        ev0_nxt    = res.ev0;
        ev1_nxt    = res.ev1;
        ev_cnt_nxt = res.cnt;
        ev_sel_nxt = 1'b0;
        if (res.cnt != 2'd0) begin
          state_nxt = ST_EMIT;
        end else if (btn_r == LAST_BTN) begin
          state_nxt = ST_FLUSH;
        end else begin
          btn_nxt   = btn_r + IDX_W'(1);
          state_nxt = ST_READ;
        end
      end
      ST_EMIT: begin
        if (!pend_v_r || out_free) begin
          // a newer event exists, so the held one is not the scan's last
          if (pend_v_r) begin
            out_v_nxt    = 1'b1;
            out_idx_nxt  = pend_idx_r;
            out_code_nxt = pend_code_r;
            out_last_nxt = 1'b0;
          end
          pend_v_nxt    = 1'b1;
          pend_idx_nxt  = BIDX_W'(btn_r);
          pend_code_nxt = ev_sel_r ? ev1_r : ev0_r;
          if (!ev_sel_r && ev_cnt_r == 2'd2) begin
            ev_sel_nxt = 1'b1;
          end else if (btn_r == LAST_BTN) begin
            state_nxt = ST_FLUSH;
          end else begin
            btn_nxt   = btn_r + IDX_W'(1);
            state_nxt = ST_READ;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_v_nxt    = 1'b1;
          out_idx_nxt  = pend_idx_r;
          out_code_nxt = pend_code_r;
          out_last_nxt = 1'b1;
          pend_v_nxt   = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {2'b00, out_code_r, out_idx_r};
  assign out_tlast  = out_last_r;

  a_calc_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CALC) |-> ($past(state_r) == ST_READ))
    else $error("evaluate without a preceding memory read");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pend_v_r)
    else $error("event left pending at end of scan");

  a_btn_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (btn_r <= LAST_BTN))
    else $error("button counter out of range");

  a_accept_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_READ && btn_r == '0))
    else $error("scan accepted without starting the walk");

  a_emit_has_events: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (ev_cnt_r != 2'd0))
    else $error("emit state with no event");

endmodule
